### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the 1-Wire search engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checks that a condition never holds while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

### hw/rtl/owrs_pkg.sv
// Types and constants of the 1-Wire ROM search engine.
package owrs_pkg;

    localparam int unsigned RomWidth = 64;
    localparam int unsigned PosWidth = 7;
    localparam int unsigned FamWidth = 8;
    localparam int unsigned FdWidth  = 4;

    localparam logic [7:0]          SEARCH_NORMAL = 8'hF0;
    localparam logic [7:0]          SEARCH_ALARM  = 8'hEC;
    localparam logic [PosWidth-1:0] POS_START     = 7'd1;
    localparam logic [PosWidth-1:0] ROM_BITS      = 7'd64;
    localparam logic [PosWidth-1:0] FAMILY_LIMIT  = 7'd9;
    localparam logic [PosWidth-1:0] POS_END       = 7'd65;

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_TARGET  = 2'd1,
        CMD_BEGIN   = 2'd2,
        CMD_PAIR    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_COMMAND = 2'd1,
        ACT_BIT     = 2'd2
    } action_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [FamWidth-1:0] family_byte;
        logic                presence;
        logic                search_sel;
        logic                id_bit;
        logic                cmp_bit;
    } item_t;

    typedef struct packed {
        action_t             action;
        logic                direction;
        logic [7:0]          rom_command;
        logic                pass_done;
        logic                found;
        logic [RomWidth-1:0] rom_id;
        logic [FdWidth-1:0]  family_discrepancy;
    } result_t;

    typedef struct packed {
        logic [RomWidth-1:0] rom_bits;
        logic [PosWidth-1:0] last_disc;
        logic [FdWidth-1:0]  last_family_disc;
        logic                last_device;
        logic                in_pass;
        logic [PosWidth-1:0] bit_position;
        logic [PosWidth-1:0] last_zero_pos;
    } search_state_t;

endpackage

### hw/rtl/owrs_if.sv
// Valid/ready channel interfaces for items and results of the search engine.
interface owrs_item_if;
    import owrs_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic [FamWidth-1:0] family_byte;
    logic                presence;
    logic                search_sel;
    logic                id_bit;
    logic                cmp_bit;

    modport source (output valid, cmd, family_byte, presence, search_sel, id_bit,
                    cmp_bit, input ready);
    modport sink (input valid, cmd, family_byte, presence, search_sel, id_bit,
                  cmp_bit, output ready);
endinterface

interface owrs_result_if;
    import owrs_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          action;
    logic                direction;
    logic [7:0]          rom_command;
    logic                pass_done;
    logic                found;
    logic [RomWidth-1:0] rom_id;
    logic [FdWidth-1:0]  family_discrepancy;

    modport source (output valid, action, direction, rom_command, pass_done, found,
                    rom_id, family_discrepancy, input ready);
    modport sink (input valid, action, direction, rom_command, pass_done, found,
                  rom_id, family_discrepancy, output ready);
endinterface

### hw/rtl/onewire_rom_search_engine.sv
// Top level of the 1-Wire ROM search engine with its result buffer.
//
//   channel | direction | transfer carries
//   --------+-----------+---------------------------------------------------
//   item    | in        | cmd, family_byte, presence, search_sel, id bits
//   result  | out       | action, direction, rom_command, pass status, rom_id
//
// Every item produces exactly one registered result; a new item can be taken
// in every cycle while the skid slot is empty. The search state lives in one
// register set updated at the item transfer, so the next item already sees it.
// Reset clears the search state and empties both result slots. When the
// result side stalls, one more item is taken into a skid slot; item.ready
// drops only while that skid slot is full.
`include "assert_macros.svh"

module onewire_rom_search_engine (
    input  logic          clk,
    input  logic          rst_n,
    owrs_item_if.sink     item,
    owrs_result_if.source result
);
    import owrs_pkg::*;

    search_state_t state_reg;
    search_state_t state_next;
    item_t         item_in;
    result_t       step_res;

    result_t out_data_reg;
    logic    out_valid_reg;
    result_t skid_data_reg;
    logic    skid_valid_reg;

    logic push;
    logic pop;

    assign item_in.cmd         = cmd_t'(item.cmd);
    assign item_in.family_byte = item.family_byte;
    assign item_in.presence    = item.presence;
    assign item_in.search_sel  = item.search_sel;
    assign item_in.id_bit      = item.id_bit;
    assign item_in.cmp_bit     = item.cmp_bit;

    owrs_step u_step (
        .cur  (state_reg),
        .item (item_in),
        .nxt  (state_next),
        .res  (step_res)
    );

    assign item.ready = !skid_valid_reg;
    assign push       = item.valid && item.ready;
    assign pop        = out_valid_reg && result.ready;

    // Search state advances once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{bit_position: POS_START, default: '0};
        end
        else if (push)
        begin
            state_reg <= state_next;
        end
    end

    // Output register plus one skid slot. New results go straight to the
    // output slot unless it is holding a result that is not being taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_data_reg <= step_res;
            else
                skid_data_reg <= step_res;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.action             = out_data_reg.action;
    assign result.direction          = out_data_reg.direction;
    assign result.rom_command        = out_data_reg.rom_command;
    assign result.pass_done          = out_data_reg.pass_done;
    assign result.found              = out_data_reg.found;
    assign result.rom_id             = out_data_reg.rom_id;
    assign result.family_discrepancy = out_data_reg.family_discrepancy;

    // The skid slot is only ever used behind a full output slot.
    `ASSERT_NEVER(a_skid_alone, clk, rst_n, skid_valid_reg && !out_valid_reg)
    // An item taken while the output is stalled must land in the skid slot.
    `ASSERT_CLK(a_skid_fill, clk, rst_n, (push && out_valid_reg && !result.ready) |=> skid_valid_reg)
    // A found ROM is always reported at the end of a pass.
    `ASSERT_CLK(a_found_done, clk, rst_n, (out_valid_reg && result.found) |-> result.pass_done)
    // During a pass the bit position stays within the 64 ROM bits.
    `ASSERT_CLK(a_pos_range, clk, rst_n, state_reg.in_pass |-> (state_reg.bit_position >= POS_START && state_reg.bit_position <= ROM_BITS))

endmodule

### hw/rtl/owrs_step.sv
// Decision logic of one search item: next search state and the result it causes.
module owrs_step (
    input  owrs_pkg::search_state_t cur,
    input  owrs_pkg::item_t         item,
    output owrs_pkg::search_state_t nxt,
    output owrs_pkg::result_t       res
);
    import owrs_pkg::*;

    always_comb
    begin
        logic                dir;
        logic [5:0]          idx;
        logic [PosWidth-1:0] bp_inc;

        nxt    = cur;
        res    = '0;
        dir    = 1'b0;
        idx    = cur.bit_position[5:0] - 6'd1;
        bp_inc = cur.bit_position + POS_START;
        res.action = ACT_NONE;

        case (item.cmd)
            CMD_RESTART:
            begin
                nxt.rom_bits         = '0;
                nxt.last_disc        = '0;
                nxt.last_family_disc = '0;
                nxt.last_device      = 1'b0;
                nxt.in_pass          = 1'b0;
                nxt.bit_position     = POS_START;
                nxt.last_zero_pos    = '0;
            end
            CMD_TARGET:
            begin
                nxt.rom_bits         = {{(RomWidth-FamWidth){1'b0}}, item.family_byte};
                nxt.last_disc        = ROM_BITS;
                nxt.last_family_disc = '0;
                nxt.last_device      = 1'b0;
                nxt.in_pass          = 1'b0;
            end
            CMD_BEGIN:
            begin
                nxt.in_pass = 1'b0;
                if (cur.last_device || !item.presence)
                begin
                    nxt.last_disc        = '0;
                    nxt.last_family_disc = '0;
                    nxt.last_device      = 1'b0;
                    res.pass_done        = 1'b1;
                end
                else
                begin
                    nxt.in_pass       = 1'b1;
                    nxt.bit_position  = POS_START;
                    nxt.last_zero_pos = '0;
                    res.action        = ACT_COMMAND;
                    res.rom_command   = item.search_sel ? SEARCH_NORMAL : SEARCH_ALARM;
                end
            end
            CMD_PAIR:
            begin
                if (cur.in_pass)
                begin
                    if (item.id_bit && item.cmp_bit)
                    begin
                        // No device answered this slot: the pass fails.
                        nxt.in_pass          = 1'b0;
                        nxt.last_disc        = '0;
                        nxt.last_family_disc = '0;
                        nxt.last_device      = 1'b0;
                        res.pass_done        = 1'b1;
                    end
                    else
                    begin
                        if (item.id_bit != item.cmp_bit)
                        begin
                            dir = item.id_bit;
                        end
                        else
                        begin
                            // Discrepancy: follow the previous path below the last
                            // branch point, take the one branch at it, else zero.
                            if (cur.bit_position < cur.last_disc)
                                dir = cur.rom_bits[idx];
                            else
                                dir = (cur.bit_position == cur.last_disc);
                            if (!dir)
                            begin
                                nxt.last_zero_pos = cur.bit_position;
                                if (cur.bit_position < FAMILY_LIMIT)
                                    nxt.last_family_disc = cur.bit_position[FdWidth-1:0];
                            end
                        end
                        nxt.rom_bits[idx] = dir;
                        nxt.bit_position  = bp_inc;
                        res.action        = ACT_BIT;
                        res.direction     = dir;
                        if (bp_inc >= POS_END)
                        begin
                            nxt.in_pass   = 1'b0;
                            res.pass_done = 1'b1;
                            nxt.last_disc = nxt.last_zero_pos;
                            if (nxt.last_zero_pos == '0)
                                nxt.last_device = 1'b1;
                            if (nxt.rom_bits[FamWidth-1:0] == '0)
                            begin
                                nxt.last_disc        = '0;
                                nxt.last_family_disc = '0;
                                nxt.last_device      = 1'b0;
                            end
                            else
                            begin
                                res.found  = 1'b1;
                                res.rom_id = nxt.rom_bits;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        res.family_discrepancy = nxt.last_family_disc;
    end

endmodule

### tb/sv/onewire_rom_search_checker.sv
// Scoreboard for the 1-Wire ROM search engine: predicts every result and compares it.
module onewire_rom_search_checker (
    input  logic        clk,
    input  logic        rst_n,
    owrs_item_if        item,
    owrs_result_if      result,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import owrs_pkg::*;

    // Search state as the engine keeps it.
    logic [RomWidth-1:0] rom_q;
    logic [PosWidth-1:0] disc_q;
    logic [FdWidth-1:0]  fam_disc_q;
    logic                last_dev_q;
    logic                in_pass_q;
    logic [PosWidth-1:0] pos_q;
    logic [PosWidth-1:0] zero_pos_q;

    result_t pending_outcomes[$];
    item_t   seen_item;
    result_t wanted;

    function automatic void forget_branches();
        disc_q     = '0;
        fam_disc_q = '0;
        last_dev_q = 1'b0;
    endfunction

    // Applies one item to the search state and returns the result it must produce.
    function automatic result_t search_outcome(input item_t it);
        result_t           r;
        logic [5:0]        idx;
        r = '0;
        case (it.cmd)
            CMD_RESTART:
            begin
                rom_q = '0;
                forget_branches();
                in_pass_q  = 1'b0;
                pos_q      = POS_START;
                zero_pos_q = '0;
            end
            CMD_TARGET:
            begin
                rom_q      = {{(RomWidth-FamWidth){1'b0}}, it.family_byte};
                disc_q     = ROM_BITS;
                fam_disc_q = '0;
                last_dev_q = 1'b0;
                in_pass_q  = 1'b0;
            end
            CMD_BEGIN:
            begin
                in_pass_q = 1'b0;
                if (last_dev_q || !it.presence)
                begin
                    forget_branches();
                    r.pass_done = 1'b1;
                end
                else
                begin
                    in_pass_q     = 1'b1;
                    pos_q         = POS_START;
                    zero_pos_q    = '0;
                    r.action      = ACT_COMMAND;
                    r.rom_command = it.search_sel ? SEARCH_NORMAL : SEARCH_ALARM;
                end
            end
            default:
            begin
                if (in_pass_q)
                begin
                    if (it.id_bit && it.cmp_bit)
                    begin
                        // Nobody answered the slot: the pass fails.
                        in_pass_q = 1'b0;
                        forget_branches();
                        r.pass_done = 1'b1;
                    end
                    else
                    begin
                        idx = pos_q[5:0] - 6'd1;
                        if (it.id_bit != it.cmp_bit)
                            r.direction = it.id_bit;
                        else
                        begin
                            // A fork: follow the last path below the old discrepancy,
                            // take the one branch at it, the zero branch beyond it.
                            if (pos_q < disc_q)
                                r.direction = rom_q[idx];
                            else
                                r.direction = (pos_q == disc_q);
                            if (!r.direction)
                            begin
                                zero_pos_q = pos_q;
                                if (zero_pos_q < FAMILY_LIMIT)
                                    fam_disc_q = zero_pos_q[FdWidth-1:0];
                            end
                        end
                        rom_q[idx] = r.direction;
                        r.action   = ACT_BIT;
                        pos_q      = pos_q + 7'd1;
                        if (pos_q >= POS_END)
                        begin
                            in_pass_q   = 1'b0;
                            r.pass_done = 1'b1;
                            disc_q      = zero_pos_q;
                            if (disc_q == '0)
                                last_dev_q = 1'b1;
                            if (rom_q[7:0] == 8'd0)
                                forget_branches();
                            else
                            begin
                                r.found  = 1'b1;
                                r.rom_id = rom_q;
                            end
                        end
                    end
                end
            end
        endcase
        r.family_discrepancy = fam_disc_q;
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_q      = '0;
            forget_branches();
            in_pass_q  = 1'b0;
            pos_q      = POS_START;
            zero_pos_q = '0;
            pending_outcomes.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            // The result of an earlier item is checked before this edge's item is predicted.
            if (result.valid && result.ready)
            begin
                if (pending_outcomes.size() == 0)
                    report("result with no item waiting, action", 64'(result.action), '0);
                else
                begin
                    wanted = pending_outcomes.pop_front();
                    if (result.action != wanted.action)
                        report("action", 64'(result.action), 64'(wanted.action));
                    if (result.direction != wanted.direction)
                        report("direction", 64'(result.direction), 64'(wanted.direction));
                    if (result.rom_command != wanted.rom_command)
                        report("rom_command", 64'(result.rom_command),
                               64'(wanted.rom_command));
                    if (result.pass_done != wanted.pass_done)
                        report("pass_done", 64'(result.pass_done), 64'(wanted.pass_done));
                    if (result.found != wanted.found)
                        report("found", 64'(result.found), 64'(wanted.found));
                    if (result.rom_id != wanted.rom_id)
                        report("rom_id", result.rom_id, wanted.rom_id);
                    if (result.family_discrepancy != wanted.family_discrepancy)
                        report("family_discrepancy", 64'(result.family_discrepancy),
                               64'(wanted.family_discrepancy));
                end
            end
            if (item.valid && item.ready)
            begin
                seen_item.cmd         = cmd_t'(item.cmd);
                seen_item.family_byte = item.family_byte;
                seen_item.presence    = item.presence;
                seen_item.search_sel  = item.search_sel;
                seen_item.id_bit      = item.id_bit;
                seen_item.cmp_bit     = item.cmp_bit;
                pending_outcomes.push_back(search_outcome(seen_item));
            end
            outstanding <= unsigned'(pending_outcomes.size());
        end
    end

endmodule

### tb/sv/onewire_rom_search_engine_tb.sv
// Top of the testbench for the 1-Wire ROM search engine: clock, reset, stimulus, verdict.
module onewire_rom_search_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import owrs_pkg::*;

    // Number of item transfers after which the stimulus stops; it also splits the
    // run into three equal stretches of sender and receiver idling.
    localparam int unsigned ItemTarget = 620;
    // Cycles with no transfer on either channel before the run is declared hung.
    // Every item gives one result, so a correct run never comes close.
    localparam int unsigned StallLimit = 1000;
    // Extra cycles after the last expected result, to catch stray results.
    localparam int unsigned DrainCycles = 4;

    logic clk;
    logic rst_n;

    owrs_item_if   item_ch();
    owrs_result_if result_ch();

    int unsigned mismatches;
    int unsigned outstanding;

    // Percent chance that the sender holds back an item, or that the receiver stalls.
    int unsigned src_idle;
    int unsigned sink_idle;
    int unsigned sent;
    int unsigned quiet_cycles = 0;

    // The device tree used by the well-formed passes: tree_bits gives the bit
    // that all devices agree on, and a set bit of tree_forks marks a position
    // where devices disagree, so the bus reads both bits as zero there.
    logic [63:0] tree_bits;
    logic [63:0] tree_forks;

    onewire_rom_search_engine i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    onewire_rom_search_checker i_scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The receiver stalls at random, at the rate of the current stretch.
    always @(posedge clk)
        result_ch.ready <= rst_n && ($urandom_range(99) >= sink_idle);

    // Watchdog: a run in which neither channel moves for too long has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // An item of the given kind with every other field random, so the engine
    // is shown that it ignores the fields that do not belong to the command.
    function automatic item_t noise_item(input cmd_t code);
        item_t it;
        it.cmd         = code;
        it.family_byte = 8'($urandom_range(255));
        it.presence    = 1'($urandom_range(1));
        it.search_sel  = 1'($urandom_range(1));
        it.id_bit      = 1'($urandom_range(1));
        it.cmp_bit     = 1'($urandom_range(1));
        return it;
    endfunction

    // Offers one item and returns once its transfer has happened. Any idle cycles
    // come first, with valid low; valid then stays high until the transfer, and is
    // only lowered by a next call that idles or when the stimulus ends, so it is
    // never dropped and raised in one step.
    task automatic push_item(input item_t it);
        while ($urandom_range(99) < src_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= it.cmd;
        item_ch.family_byte <= it.family_byte;
        item_ch.presence    <= it.presence;
        item_ch.search_sel  <= it.search_sel;
        item_ch.id_bit      <= it.id_bit;
        item_ch.cmp_bit     <= it.cmp_bit;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sent++;
        // First the sender idles less than the receiver, then the other way round,
        // and in the last stretch neither side idles at all.
        if (sent < ItemTarget / 3)
        begin
            src_idle  = 25;
            sink_idle = 50;
        end
        else if (sent < 2 * ItemTarget / 3)
        begin
            src_idle  = 50;
            sink_idle = 25;
        end
        else
        begin
            src_idle  = 0;
            sink_idle = 0;
        end
    endtask

    task automatic send_pair(input logic idb, input logic cmpb);
        item_t it;
        it         = noise_item(CMD_PAIR);
        it.id_bit  = idb;
        it.cmp_bit = cmpb;
        push_item(it);
    endtask

    task automatic send_begin(input logic pres, input logic mode);
        item_t it;
        it            = noise_item(CMD_BEGIN);
        it.presence   = pres;
        it.search_sel = mode;
        push_item(it);
    endtask

    task automatic send_target(input logic [7:0] fam);
        item_t it;
        it             = noise_item(CMD_TARGET);
        it.family_byte = fam;
        push_item(it);
    endtask

    // Picks a new device tree. Some shapes are forced because they lead to the
    // rarer endings: a lone device ends the search on its first pass, and an all
    // zero family byte makes the pass fail after its last bit.
    task automatic grow_tree(input int unsigned shape);
        tree_bits  = {$urandom, $urandom};
        tree_forks = {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
        case (shape)
            0: tree_forks = '0;
            1:
            begin
                tree_bits[7:0]  = '0;
                tree_forks[7:0] = '0;
            end
            2: tree_forks[7:0] = 8'($urandom_range(255));
            3: tree_bits = '1;
            4: tree_bits = '0;
            default: ;
        endcase
    endtask

    // Reads the first count bit pairs of the current tree off the bus.
    task automatic run_pairs(input int unsigned count);
        for (int unsigned p = 0; p < count; p++)
        begin
            if (tree_forks[p])
                send_pair(1'b0, 1'b0);
            else
                send_pair(tree_bits[p], ~tree_bits[p]);
        end
    endtask

    task automatic full_pass();
        send_begin(1'b1, 1'($urandom_range(1)));
        run_pairs(64);
    endtask

    initial
    begin
        int unsigned pick;
        rst_n                 = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.cmd           = CMD_RESTART;
        item_ch.family_byte   = '0;
        item_ch.presence      = 1'b0;
        item_ch.search_sel    = 1'b0;
        item_ch.id_bit        = 1'b0;
        item_ch.cmp_bit       = 1'b0;
        src_idle              = 25;
        sink_idle             = 50;
        sent                  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: every command, extreme family bytes, and the short
        // special cases of the search.
        push_item(noise_item(CMD_RESTART));
        // Bit pairs outside a pass are ignored, whatever they read.
        send_pair(1'b1, 1'b1);
        send_pair(1'b0, 1'b1);
        // A bus reset that saw no presence pulse ends the pass at once.
        send_begin(1'b0, 1'b1);
        send_target(8'hFF);
        // Alarm search, then a slot where both read bits are one.
        send_begin(1'b1, 1'b0);
        send_pair(1'b1, 1'b1);
        send_target(8'h00);
        send_begin(1'b1, 1'b1);
        send_pair(1'b0, 1'b0);
        send_pair(1'b1, 1'b0);
        // A new pass started while one is running drops the old one.
        send_begin(1'b1, 1'b0);
        send_pair(1'b0, 1'b1);
        send_pair(1'b0, 1'b0);
        // A restart in the middle of a pass.
        push_item(noise_item(CMD_RESTART));
        send_pair(1'b1, 1'b0);
        send_begin(1'b1, 1'b1);
        send_pair(1'b0, 1'b0);
        // No presence while a pass is running.
        send_begin(1'b0, 1'b0);
        send_target(8'h80);
        send_pair(1'b0, 1'b0);

        // Two complete passes lead the random part: a device with a zero family
        // byte, then a lone device, whose search ends on the following bus reset.
        push_item(noise_item(CMD_RESTART));
        grow_tree(1);
        full_pass();
        grow_tree(0);
        full_pass();
        send_begin(1'b1, 1'b1);
        push_item(noise_item(CMD_RESTART));
        grow_tree($urandom_range(7));

        // Random part. Most items belong to complete passes over one tree, so
        // that later passes walk the branches that earlier passes left open.
        while (sent < ItemTarget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                full_pass();
            else if (pick < 80)
            begin
                // A pass broken off partway by a failed slot, a fresh bus reset,
                // a restart or a family target.
                send_begin(1'b1, 1'($urandom_range(1)));
                run_pairs($urandom_range(63));
                case ($urandom_range(3))
                    0: send_pair(1'b1, 1'b1);
                    1: send_begin(1'($urandom_range(1)), 1'($urandom_range(1)));
                    2: push_item(noise_item(CMD_RESTART));
                    default: send_target(8'($urandom_range(255)));
                endcase
            end
            else if (pick < 90)
                push_item(noise_item(cmd_t'($urandom_range(3))));
            else
            begin
                // A new search: either from scratch or aimed at one family.
                if ($urandom_range(1))
                    push_item(noise_item(CMD_RESTART));
                else
                    send_target(8'($urandom_range(255)));
                grow_tree($urandom_range(7));
            end
        end
        item_ch.valid <= 1'b0;

        // Wait for the last results, then the drain time for stray ones;
        // the watchdog bounds this wait. The first edge lets the count take in
        // the last item.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
